// File: hw/rtl/pack_entry_header_parser_top_assert.svh
// Assertion macros shared by the pack entry header parser
`ifndef PACK_ENTRY_HEADER_PARSER_TOP_ASSERT_SVH
`define PACK_ENTRY_HEADER_PARSER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define PEHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset
`define PEHP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/pehp_pkg.sv
`default_nettype none

package pehp_pkg;

  localparam int unsigned HashBytes = 20;
  localparam logic [4:0]  HashLast  = 5'(HashBytes - 1);

  localparam logic [2:0] KindCommit   = 3'd1;
  localparam logic [2:0] KindTree     = 3'd2;
  localparam logic [2:0] KindBlob     = 3'd3;
  localparam logic [2:0] KindTag      = 3'd4;
  localparam logic [2:0] KindOfsDelta = 3'd6;
  localparam logic [2:0] KindRefDelta = 3'd7;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_SIZE_OVF  = 3'd2,
    ST_OFS_OVF   = 3'd3,
    ST_BASE_LATE = 3'd4,
    ST_STRAY     = 3'd5
  } status_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic [63:0] entry_position;
  } item_t;

  typedef struct packed {
    logic        done_res;
    status_e     status;
    logic [2:0]  kind;
    logic [63:0] object_size;
    logic [63:0] base_position;
    logic        hash_valid;
    logic [7:0]  hash_byte;
    logic [4:0]  hash_index;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pehp_core.sv
`default_nettype none

module pehp_core
  import pehp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  output result_t      result_o
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SIZE      = 3'd1,
    PH_OFS_FIRST = 3'd2,
    PH_OFS_MORE  = 3'd3,
    PH_HASH      = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  kind_q, kind_d;
  logic [63:0] size_q, size_d;
  logic [6:0]  shift_q, shift_d;
  logic [63:0] ofs_q, ofs_d;
  logic [63:0] start_q, start_d;
  logic [4:0]  hcnt_q, hcnt_d;

  logic [7:0]  b;
  logic [6:0]  chunk;
  logic [70:0] shifted;
  logic        size_ovf;
  logic [63:0] v;
  logic [63:0] v_inc;
  logic        sz_end;
  logic        stray;

  assign b       = item_i.data_byte;
  assign chunk   = b[6:0];
  assign shifted = {64'd0, chunk} << shift_q[5:0];
  assign size_ovf = shift_q[6] ? (chunk != 7'd0) : (shifted[70:64] != 7'd0);
  assign v       = (phase_q == PH_OFS_FIRST) ? {57'd0, chunk}
                                             : ({ofs_q[56:0], 7'd0} + {57'd0, chunk});
  assign v_inc   = v + 64'd1;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    size_d  = size_q;
    shift_d = shift_q;
    ofs_d   = ofs_q;
    start_d = start_q;
    hcnt_d  = hcnt_q;
    sz_end  = 1'b0;
    stray   = 1'b0;
    result_o = '0;
    result_o.status = ST_OK;

    if (!item_i.action) begin
      start_d = item_i.entry_position;
      kind_d  = b[6:4];
      size_d  = {60'd0, b[3:0]};
      shift_d = 7'd4;
      ofs_d   = '0;
      hcnt_d  = '0;
      if (b[7]) begin
        phase_d = PH_SIZE;
      end else begin
        sz_end = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_SIZE: begin
          if (size_ovf) begin
            phase_d = PH_IDLE;
            result_o.done_res = 1'b1;
            result_o.status   = ST_SIZE_OVF;
          end else begin
            if (!shift_q[6]) begin
              size_d  = size_q | shifted[63:0];
              shift_d = shift_q + 7'd7;
            end
            if (!b[7]) begin
              sz_end = 1'b1;
            end
          end
        end
        PH_OFS_FIRST, PH_OFS_MORE: begin
          if (b[7]) begin
            if (v_inc == 64'd0 || v_inc[63:57] != 7'd0) begin
              phase_d = PH_IDLE;
              result_o.done_res = 1'b1;
              result_o.status   = ST_OFS_OVF;
            end else begin
              ofs_d   = v_inc;
              phase_d = PH_OFS_MORE;
            end
          end else begin
            ofs_d   = v;
            phase_d = PH_IDLE;
            result_o.done_res = 1'b1;
            if (v == 64'd0 || v >= start_q) begin
              result_o.status = ST_BASE_LATE;
            end else begin
              result_o.base_position = start_q - v;
            end
          end
        end
        PH_HASH: begin
          result_o.hash_valid = 1'b1;
          result_o.hash_byte  = b;
          result_o.hash_index = hcnt_q;
          hcnt_d = hcnt_q + 5'd1;
          if (hcnt_q == HashLast) begin
            phase_d = PH_IDLE;
            result_o.done_res = 1'b1;
          end
        end
        default: begin
          stray = 1'b1;
          result_o.done_res = 1'b1;
          result_o.status   = ST_STRAY;
        end
      endcase
    end

    if (sz_end) begin
      case (kind_d)
        KindCommit, KindTree, KindBlob, KindTag: begin
          phase_d = PH_IDLE;
          result_o.done_res = 1'b1;
        end
        KindOfsDelta: begin
          phase_d = PH_OFS_FIRST;
        end
        KindRefDelta: begin
          phase_d = PH_HASH;
          hcnt_d  = '0;
        end
        default: begin
          phase_d = PH_IDLE;
          result_o.done_res = 1'b1;
          result_o.status   = ST_BAD_TYPE;
        end
      endcase
    end

    result_o.kind        = stray ? 3'd0 : kind_d;
    result_o.object_size = stray ? 64'd0 : size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= '0;
      size_q  <= '0;
      shift_q <= '0;
      ofs_q   <= '0;
      start_q <= '0;
      hcnt_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      size_q  <= size_d;
      shift_q <= shift_d;
      ofs_q   <= ofs_d;
      start_q <= start_d;
      hcnt_q  <= hcnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pack_entry_header_parser_top.sv
// Channel | Handshake               | Beat fields
// --------+-------------------------+-------------------------------------------------
// in      | in_valid_i / in_stall_o | action_i, data_byte_i, entry_position_i
// out     | out_valid_o/ out_stall_i| done_res_o, status_o, kind_o, object_size_o,
//         |                         | base_position_o, hash_valid_o, hash_byte_o,
//         |                         | hash_index_o
//
// One result beat per input beat; one beat per cycle sustained while the output is not stalled.
// Each beat passes the input register, then header step logic into the result register.
// The per-byte shift, add and base subtract set the cycle; parser state updates once per beat.
// Reset clears parser state and both valid flags; no clearing pass is needed.
// An output stall holds the result register; a held input beat then stalls the input.

`default_nettype none

`include "pack_entry_header_parser_top_assert.svh"

module pack_entry_header_parser_top
  import pehp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [63:0] entry_position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             done_res_o,
  output logic [2:0]       status_o,
  output logic [2:0]       kind_o,
  output logic [63:0]      object_size_o,
  output logic [63:0]      base_position_o,
  output logic             hash_valid_o,
  output logic [7:0]       hash_byte_o,
  output logic [4:0]       hash_index_o
);

  logic    iv_q;
  item_t   item_q;
  logic    ov_q;
  result_t res_q;
  result_t res_d;
  logic    out_free;
  logic    step;
  logic    in_fire;

  assign out_free   = !ov_q || !out_stall_i;
  assign step       = iv_q && out_free;
  assign in_stall_o = iv_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (in_fire) begin
        iv_q <= 1'b1;
      end else if (step) begin
        iv_q <= 1'b0;
      end
      if (step) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action         <= action_i;
      item_q.data_byte      <= data_byte_i;
      item_q.entry_position <= entry_position_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  pehp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_valid_o     = ov_q;
  assign done_res_o      = res_q.done_res;
  assign status_o        = res_q.status;
  assign kind_o          = res_q.kind;
  assign object_size_o   = res_q.object_size;
  assign base_position_o = res_q.base_position;
  assign hash_valid_o    = res_q.hash_valid;
  assign hash_byte_o     = res_q.hash_byte;
  assign hash_index_o    = res_q.hash_index;

  `PEHP_ASSERT(a_step_lands, step |=> ov_q, "stepped beat not held in result register")
  `PEHP_ASSERT_NEVER(a_err_open, ov_q && res_q.status != ST_OK && !res_q.done_res,
      "error status without end of header")
  `PEHP_ASSERT(a_hash_kind, (ov_q && res_q.hash_valid) |-> (res_q.kind == KindRefDelta),
      "hash byte outside a reference delta")
  `PEHP_ASSERT(a_base_ok, (ov_q && res_q.base_position != 64'd0) |->
      (res_q.done_res && res_q.status == ST_OK && res_q.kind == KindOfsDelta),
      "base position outside a finished offset delta")
  `PEHP_ASSERT(a_stray_clear, (ov_q && res_q.status == ST_STRAY) |->
      (res_q.kind == 3'd0 && res_q.object_size == 64'd0), "stray beat carries data")

endmodule

`default_nettype wire

// File: test/pack_entry_header_parser_top_tb.sv
`default_nettype none

module pack_entry_header_parser_top_tb
  import pehp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  KindNone     = 3'd0;
  localparam logic [2:0]  KindReserved = 3'd5;
  localparam logic [63:0] PosMax       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned RunLimit     = 200000;
  localparam int unsigned RandomBeats  = 900;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE,
    PH_OFS_FIRST,
    PH_OFS_MORE,
    PH_HASH
  } parse_phase_e;

  typedef struct {
    item_t   beat;
    bit      given;
    result_t want;
  } header_beat_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        action_i         = 1'b0;
  logic [7:0]  data_byte_i      = 8'd0;
  logic [63:0] entry_position_i = 64'd0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic        done_res_o;
  logic [2:0]  status_o;
  logic [2:0]  kind_o;
  logic [63:0] object_size_o;
  logic [63:0] base_position_o;
  logic        hash_valid_o;
  logic [7:0]  hash_byte_o;
  logic [4:0]  hash_index_o;

  header_beat_t header_beats[$];
  result_t      header_results_due[$];
  int unsigned  cycle_cnt = 0;
  int unsigned  errors    = 0;
  bit           sent_all  = 1'b0;

  // parser state as seen by the predictor
  parse_phase_e parse_phase = PH_IDLE;
  logic [2:0]   cur_kind    = '0;
  logic [63:0]  size_acc    = '0;
  logic [6:0]   size_shift  = '0;
  logic [63:0]  ofs_acc     = '0;
  logic [63:0]  entry_start = '0;
  logic [4:0]   hash_count  = '0;

  pack_entry_header_parser_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic result_t header_end(logic done, status_e st, logic [2:0] kind,
                                         logic [63:0] size);
    result_t r;
    r             = '0;
    r.done_res    = done;
    r.status      = st;
    r.kind        = kind;
    r.object_size = size;
    return r;
  endfunction

  function automatic result_t size_done();
    result_t r;
    r = '0;
    case (cur_kind)
      KindCommit, KindTree, KindBlob, KindTag: begin
        parse_phase = PH_IDLE;
        r.done_res  = 1'b1;
      end
      KindOfsDelta: parse_phase = PH_OFS_FIRST;
      KindRefDelta: begin
        parse_phase = PH_HASH;
        hash_count  = '0;
      end
      default: begin
        parse_phase = PH_IDLE;
        r.done_res  = 1'b1;
        r.status    = ST_BAD_TYPE;
      end
    endcase
    return r;
  endfunction

  function automatic result_t parse_header_byte(item_t it);
    result_t     r;
    logic [63:0] chunk;
    logic [63:0] v;
    logic [4:0]  idx;
    r     = '0;
    chunk = {57'd0, it.data_byte[6:0]};
    if (!it.action) begin
      entry_start = it.entry_position;
      cur_kind    = it.data_byte[6:4];
      size_acc    = {60'd0, it.data_byte[3:0]};
      size_shift  = 7'd4;
      ofs_acc     = '0;
      hash_count  = '0;
      if (it.data_byte[7]) parse_phase = PH_SIZE;
      else r = size_done();
    end else begin
      case (parse_phase)
        PH_SIZE: begin
          if ((size_shift >= 7'd64 && chunk != 0) ||
              (size_shift < 7'd64 && size_shift > 7'd57 &&
               (chunk >> (7'd64 - size_shift)) != 0)) begin
            parse_phase = PH_IDLE;
            r.done_res  = 1'b1;
            r.status    = ST_SIZE_OVF;
          end else begin
            if (size_shift < 7'd64) begin
              size_acc   = size_acc | (chunk << size_shift);
              size_shift = size_shift + 7'd7;
            end
            if (!it.data_byte[7]) r = size_done();
          end
        end
        PH_OFS_FIRST, PH_OFS_MORE: begin
          v = (parse_phase == PH_OFS_FIRST) ? chunk : (ofs_acc << 7) + chunk;
          if (it.data_byte[7]) begin
            v = v + 64'd1;
            if (v == 0 || v[63:57] != 0) begin
              parse_phase = PH_IDLE;
              r.done_res  = 1'b1;
              r.status    = ST_OFS_OVF;
            end else begin
              ofs_acc     = v;
              parse_phase = PH_OFS_MORE;
            end
          end else begin
            ofs_acc     = v;
            parse_phase = PH_IDLE;
            r.done_res  = 1'b1;
            if (v == 0 || v >= entry_start) r.status = ST_BASE_LATE;
            else r.base_position = entry_start - v;
          end
        end
        PH_HASH: begin
          idx          = hash_count;
          hash_count   = idx + 5'd1;
          r.hash_valid = 1'b1;
          r.hash_byte  = it.data_byte;
          r.hash_index = idx;
          if (hash_count >= HashBytes) begin
            parse_phase = PH_IDLE;
            r.done_res  = 1'b1;
          end
        end
        default: begin
          r.done_res = 1'b1;
          r.status   = ST_STRAY;
          return r;
        end
      endcase
    end
    r.kind        = cur_kind;
    r.object_size = size_acc;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("done=%0b status=%0d kind=%0d size=%h base=%h hash=%0b/%h/%0d",
                     r.done_res, r.status, r.kind, r.object_size, r.base_position,
                     r.hash_valid, r.hash_byte, r.hash_index);
  endfunction

  task automatic push_beat(logic act, logic [7:0] b, logic [63:0] pos, bit given = 1'b0,
                           result_t want = '0);
    header_beat_t row;
    row.beat.action         = act;
    row.beat.data_byte      = b;
    row.beat.entry_position = pos;
    row.given               = given;
    row.want                = want;
    header_beats.push_back(row);
  endtask

  function automatic logic [63:0] random_position();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return PosMax;
      2:       return 64'($urandom_range(0, 4096));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int group_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 2);
    if (r < 9) return $urandom_range(3, 7);
    return $urandom_range(8, 10);
  endfunction

  function automatic logic [6:0] random_group(int fill);
    case (fill)
      0:       return 7'h00;
      1:       return 7'h7f;
      default: return 7'($urandom);
    endcase
  endfunction

  task automatic add_random_entry();
    logic [7:0]  seq[$];
    logic [63:0] pos;
    logic [2:0]  kind;
    int          pick, fill, ngroups, i;
    pick = $urandom_range(0, 99);
    fill = $urandom_range(0, 3);
    pos  = random_position();
    if (pick < 6) begin
      repeat ($urandom_range(1, 3)) push_beat(1'b1, 8'($urandom), random_position());
      return;
    end
    if (pick < 14) kind = ($urandom_range(0, 1) != 0) ? KindReserved : KindNone;
    else if (pick < 44) kind = 3'($urandom_range(KindCommit, KindTag));
    else if (pick < 72) kind = KindOfsDelta;
    else kind = KindRefDelta;
    ngroups = group_count();
    seq.push_back({ngroups != 0, kind, 4'($urandom)});
    for (i = 0; i < ngroups; i++) seq.push_back({i != ngroups - 1, random_group(fill)});
    if (kind == KindOfsDelta) begin
      ngroups = group_count() + 1;
      fill    = $urandom_range(0, 3);
      for (i = 0; i < ngroups; i++) seq.push_back({i != ngroups - 1, random_group(fill)});
    end else if (kind == KindRefDelta) begin
      repeat (HashBytes) seq.push_back(8'($urandom));
    end
    // cut some headers short so that the next entry abandons them
    if ($urandom_range(0, 9) == 0) seq = seq[0:$urandom_range(0, seq.size() - 1)];
    push_beat(1'b0, seq[0], pos);
    for (i = 1; i < seq.size(); i++) push_beat(1'b1, seq[i], random_position());
    if ($urandom_range(0, 19) == 0) push_beat(1'b1, 8'($urandom), random_position());
  endtask

  initial begin : sender
    int     idx, gap, burst;
    int     n;
    item_t  it;
    result_t predicted;
    burst = 0;

    push_beat(1'b1, 8'h55, 64'd0, 1'b1, header_end(1'b1, ST_STRAY, KindNone, 64'd0));
    push_beat(1'b0, 8'h00, 64'd0, 1'b1, header_end(1'b1, ST_BAD_TYPE, KindNone, 64'd0));
    push_beat(1'b0, 8'h5F, PosMax, 1'b1,
              header_end(1'b1, ST_BAD_TYPE, KindReserved, 64'd15));
    push_beat(1'b1, 8'hFF, PosMax, 1'b1, header_end(1'b1, ST_STRAY, KindNone, 64'd0));
    push_beat(1'b0, 8'h9F, 64'd0);
    push_beat(1'b0, 8'h60, PosMax);
    push_beat(1'b1, 8'h86, 64'd0);
    push_beat(1'b1, 8'h00, 64'd0);
    push_beat(1'b0, 8'h60, 64'd5);
    push_beat(1'b1, 8'h05, 64'd0, 1'b1,
              header_end(1'b1, ST_BASE_LATE, KindOfsDelta, 64'd0));
    push_beat(1'b0, 8'h60, PosMax);
    repeat (8) push_beat(1'b1, 8'hFF, 64'd0);
    push_beat(1'b1, 8'hFF, 64'd0, 1'b1,
              header_end(1'b1, ST_OFS_OVF, KindOfsDelta, 64'd0));
    push_beat(1'b0, 8'hBF, 64'd0);
    repeat (8) push_beat(1'b1, 8'hFF, 64'd0);
    push_beat(1'b1, 8'h7F, 64'd0, 1'b1,
              header_end(1'b1, ST_SIZE_OVF, KindBlob, 64'h0FFF_FFFF_FFFF_FFFF));
    n = header_beats.size();
    while (header_beats.size() < n + RandomBeats) add_random_entry();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < header_beats.size(); idx++) begin
      if (burst == 0) begin
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        burst = $urandom_range(1, 24);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      it = header_beats[idx].beat;
      in_valid_i       <= 1'b1;
      action_i         <= it.action;
      data_byte_i      <= it.data_byte;
      entry_position_i <= it.entry_position;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      predicted = parse_header_byte(it);
      header_results_due.push_back(header_beats[idx].given ? header_beats[idx].want :
                                   predicted);
      burst--;
    end
    in_valid_i <= 1'b0;
    sent_all   = 1'b1;
  end

  initial begin : receiver
    int      span, style;
    result_t got, want;
    span  = 0;
    style = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.done_res      = done_res_o;
        got.status        = status_e'(status_o);
        got.kind          = kind_o;
        got.object_size   = object_size_o;
        got.base_position = base_position_o;
        got.hash_valid    = hash_valid_o;
        got.hash_byte     = hash_byte_o;
        got.hash_index    = hash_index_o;
        if (header_results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = header_results_due.pop_front();
          if (got.done_res !== want.done_res || got.status !== want.status ||
              got.kind !== want.kind || got.object_size !== want.object_size ||
              got.base_position !== want.base_position ||
              got.hash_valid !== want.hash_valid || got.hash_byte !== want.hash_byte ||
              got.hash_index !== want.hash_index) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at cycle %0d", cycle_cnt);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(20, 200);
      end
      span--;
      case (style)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= (cycle_cnt % 7) < 3;
        default: out_stall_i <= ($urandom_range(0, 9) == 0) ? ~out_stall_i : out_stall_i;
      endcase
    end
  end

  initial begin : finish_run
    @(posedge rst_ni);
    while (!(sent_all && header_results_due.size() == 0) && cycle_cnt < RunLimit)
      @(posedge clk_i);
    // drain: catch any extra result beats
    repeat (8) @(posedge clk_i);
    if (errors == 0 && header_results_due.size() == 0 && cycle_cnt < RunLimit)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pehp_pkg.sv
hw/rtl/pehp_core.sv
hw/rtl/pack_entry_header_parser_top.sv
test/pack_entry_header_parser_top_tb.sv
